@@ design/cerl_pkg.sv @@
// Shared types and constants for the character entity reference lexer.
// Holds state codes, character classes, completion kinds and the queue item.
// No dependencies.
`default_nettype none

package cerl_pkg;

  // Width of the numeric accumulator.
  localparam int VALUE_BITS = 32;
  localparam int OUT_VALUE_W = 32;

  typedef logic [3:0] lex_state_t;

  localparam lex_state_t ST_REJECT    = 4'd0;
  localparam lex_state_t ST_START     = 4'd1;
  localparam lex_state_t ST_AMP       = 4'd2;
  localparam lex_state_t ST_NAME      = 4'd3;
  localparam lex_state_t ST_NAME_DONE = 4'd4;
  localparam lex_state_t ST_HASH      = 4'd5;
  localparam lex_state_t ST_DEC       = 4'd6;
  localparam lex_state_t ST_HEX_X     = 4'd7;
  localparam lex_state_t ST_HEX       = 4'd8;
  localparam lex_state_t ST_NUM_DONE  = 4'd9;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_AMP    = 3'd1,
    CLS_LETTER = 3'd2,
    CLS_SEMI   = 3'd3,
    CLS_HASH   = 3'd4,
    CLS_XCHAR  = 3'd5,
    CLS_HEXL   = 3'd6,
    CLS_DIGIT  = 3'd7
  } char_class_t;

  typedef logic [1:0] done_kind_t;

  localparam done_kind_t DONE_NONE    = 2'd0;
  localparam done_kind_t DONE_NAMED   = 2'd1;
  localparam done_kind_t DONE_NUMERIC = 2'd2;

  localparam logic ACT_FEED    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic        action;
    char_class_t cls;
    logic [3:0]  digit;
  } lex_item_t;

endpackage : cerl_pkg

`default_nettype wire

@@ design/cerl_if.sv @@
// Valid/ready channel interfaces of the entity reference lexer.
// Depends on nothing but the field widths of the block.
`default_nettype none

interface cerl_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] code_unit;

  modport source (output valid, output action, output code_unit, input ready);
  modport sink (input valid, input action, input code_unit, output ready);
endinterface : cerl_in_if

interface cerl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  state_now;
  logic [1:0]  done_kind;
  logic [31:0] numeric_value;
  logic        too_big;

  modport source (output valid, output state_now, output done_kind,
                  output numeric_value, output too_big, input ready);
  modport sink (input valid, input state_now, input done_kind,
                input numeric_value, input too_big, output ready);
endinterface : cerl_out_if

`default_nettype wire

@@ design/cerl_front.sv @@
// Front part: accepts input requests, classifies the character and
// extracts its digit value into a registered item. Uses cerl_pkg and cerl_in_if.
`default_nettype none

module cerl_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  cerl_in_if.sink              in_ch,
  output cerl_pkg::lex_item_t  item_o,
  output logic                 item_valid_o,
  input  wire logic            item_ready_i
);

  logic                valid_r;
  cerl_pkg::lex_item_t item_r;
  cerl_pkg::lex_item_t item_nxt;
  logic                take;

  function automatic cerl_pkg::char_class_t classify(input logic [7:0] c);
    cerl_pkg::char_class_t cls;
    cls = cerl_pkg::CLS_NONE;
    if (c == 8'h26) cls = cerl_pkg::CLS_AMP;
    else if (c == 8'h3B) cls = cerl_pkg::CLS_SEMI;
    else if (c == 8'h23) cls = cerl_pkg::CLS_HASH;
    else if (c == 8'h78 || c == 8'h58) cls = cerl_pkg::CLS_XCHAR;
    else if (c >= 8'h30 && c <= 8'h39) cls = cerl_pkg::CLS_DIGIT;
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      cls = cerl_pkg::CLS_HEXL;
    else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A))
      cls = cerl_pkg::CLS_LETTER;
    return cls;
  endfunction

  always_comb begin
    item_nxt.action = in_ch.action;
    item_nxt.cls    = classify(in_ch.code_unit);
    // Letters a-f and A-F share their low nibble, offset by nine from the value.
    if (item_nxt.cls == cerl_pkg::CLS_DIGIT) begin
      item_nxt.digit = in_ch.code_unit[3:0];
    end else begin
      item_nxt.digit = in_ch.code_unit[3:0] + 4'd9;
    end
  end

  assign in_ch.ready  = !valid_r || item_ready_i;
  assign take         = in_ch.valid && in_ch.ready;
  assign item_o       = item_r;
  assign item_valid_o = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
    if (take) begin
      item_r <= item_nxt;
    end
  end

endmodule : cerl_front

`default_nettype wire

@@ design/cerl_queue.sv @@
// Two-entry queue of classified items between front and back.
// Uses cerl_pkg for the item type.
`default_nettype none

module cerl_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cerl_pkg::lex_item_t  push_item_i,
  input  wire logic                 push_valid_i,
  output logic                      push_ready_o,
  output cerl_pkg::lex_item_t       pop_item_o,
  output logic                      pop_valid_o,
  input  wire logic                 pop_ready_i
);

  cerl_pkg::lex_item_t slots_r [2];
  logic                wr_ptr_r;
  logic                rd_ptr_r;
  logic [1:0]          count_r;
  logic                push;
  logic                pop;

  assign push_ready_o = (count_r != 2'd2);
  assign pop_valid_o  = (count_r != 2'd0);
  assign pop_item_o   = slots_r[rd_ptr_r];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
    if (push) begin
      slots_r[wr_ptr_r] <= push_item_i;
    end
  end

endmodule : cerl_queue

`default_nettype wire

@@ design/cerl_back.sv @@
// Back part: runs the entity automaton and the numeric accumulator on
// classified items, and holds the result register. Uses cerl_pkg and cerl_out_if.
`default_nettype none

module cerl_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cerl_pkg::lex_item_t  item_i,
  input  wire logic                 item_valid_i,
  output logic                      item_ready_o,
  cerl_out_if.source                out_ch
);

  localparam int VW = cerl_pkg::VALUE_BITS;
  localparam int WW = cerl_pkg::VALUE_BITS + 4;

  cerl_pkg::lex_state_t state_r, state_nxt, trans;
  logic [VW-1:0]        accum_r, accum_nxt;
  logic                 ovf_r, ovf_nxt;
  cerl_pkg::done_kind_t done_nxt;
  logic                 out_valid_r;
  cerl_pkg::lex_state_t out_state_r;
  cerl_pkg::done_kind_t out_done_r;
  logic [VW-1:0]        out_value_r;
  logic                 out_ovf_r;
  logic [WW-1:0]        dec_sum;
  logic [WW-1:0]        hex_sum;
  logic                 pop;

  function automatic cerl_pkg::lex_state_t next_state(
    input cerl_pkg::lex_state_t s, input cerl_pkg::char_class_t c);
    cerl_pkg::lex_state_t n;
    n = cerl_pkg::ST_REJECT;
    unique case (s)
      cerl_pkg::ST_START: begin
        if (c == cerl_pkg::CLS_AMP) n = cerl_pkg::ST_AMP;
      end
      cerl_pkg::ST_AMP: begin
        case (c) inside
          cerl_pkg::CLS_LETTER, cerl_pkg::CLS_XCHAR, cerl_pkg::CLS_HEXL:
            n = cerl_pkg::ST_NAME;
          cerl_pkg::CLS_HASH: n = cerl_pkg::ST_HASH;
          default: n = cerl_pkg::ST_REJECT;
        endcase
      end
      cerl_pkg::ST_NAME: begin
        case (c) inside
          cerl_pkg::CLS_LETTER, cerl_pkg::CLS_XCHAR, cerl_pkg::CLS_HEXL,
          cerl_pkg::CLS_DIGIT: n = cerl_pkg::ST_NAME;
          cerl_pkg::CLS_SEMI: n = cerl_pkg::ST_NAME_DONE;
          default: n = cerl_pkg::ST_REJECT;
        endcase
      end
      cerl_pkg::ST_HASH: begin
        case (c)
          cerl_pkg::CLS_XCHAR: n = cerl_pkg::ST_HEX_X;
          cerl_pkg::CLS_DIGIT: n = cerl_pkg::ST_DEC;
          default: n = cerl_pkg::ST_REJECT;
        endcase
      end
      cerl_pkg::ST_DEC: begin
        case (c)
          cerl_pkg::CLS_SEMI:  n = cerl_pkg::ST_NUM_DONE;
          cerl_pkg::CLS_DIGIT: n = cerl_pkg::ST_DEC;
          default: n = cerl_pkg::ST_REJECT;
        endcase
      end
      cerl_pkg::ST_HEX_X: begin
        case (c) inside
          cerl_pkg::CLS_HEXL, cerl_pkg::CLS_DIGIT: n = cerl_pkg::ST_HEX;
          default: n = cerl_pkg::ST_REJECT;
        endcase
      end
      cerl_pkg::ST_HEX: begin
        case (c) inside
          cerl_pkg::CLS_SEMI: n = cerl_pkg::ST_NUM_DONE;
          cerl_pkg::CLS_HEXL, cerl_pkg::CLS_DIGIT: n = cerl_pkg::ST_HEX;
          default: n = cerl_pkg::ST_REJECT;
        endcase
      end
      default: n = cerl_pkg::ST_REJECT;
    endcase
    return n;
  endfunction

  // Exact value of accum * base + digit; anything above the low VW bits is overflow.
  assign dec_sum = (WW'(accum_r) << 3) + (WW'(accum_r) << 1) + WW'(item_i.digit);
  assign hex_sum = {accum_r, item_i.digit};
  assign trans   = next_state(state_r, item_i.cls);

  always_comb begin
    state_nxt = state_r;
    accum_nxt = accum_r;
    ovf_nxt   = ovf_r;
    done_nxt  = cerl_pkg::DONE_NONE;
    if (item_i.action == cerl_pkg::ACT_RESTART) begin
      state_nxt = cerl_pkg::ST_START;
    end else begin
      state_nxt = trans;
      case (trans)
        cerl_pkg::ST_NAME_DONE: done_nxt = cerl_pkg::DONE_NAMED;
        cerl_pkg::ST_HASH: begin
          accum_nxt = '0;
          ovf_nxt   = 1'b0;
        end
        cerl_pkg::ST_DEC: begin
          accum_nxt = dec_sum[VW-1:0];
          if (dec_sum[WW-1:VW] != '0) ovf_nxt = 1'b1;
        end
        cerl_pkg::ST_HEX: begin
          accum_nxt = hex_sum[VW-1:0];
          if (hex_sum[WW-1:VW] != '0) ovf_nxt = 1'b1;
        end
        cerl_pkg::ST_NUM_DONE: done_nxt = cerl_pkg::DONE_NUMERIC;
        default: ;
      endcase
    end
  end

  assign item_ready_o = !out_valid_r || out_ch.ready;
  assign pop          = item_valid_i && item_ready_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cerl_pkg::ST_START;
      accum_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_ready_o) out_valid_r <= item_valid_i;
      if (pop) begin
        state_r <= state_nxt;
        accum_r <= accum_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
    if (pop) begin
      out_state_r <= state_nxt;
      out_done_r  <= done_nxt;
      out_value_r <= accum_nxt;
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.state_now     = out_state_r;
  assign out_ch.done_kind     = out_done_r;
  assign out_ch.numeric_value = cerl_pkg::OUT_VALUE_W'(out_value_r);
  assign out_ch.too_big       = out_ovf_r;

endmodule : cerl_back

`default_nettype wire

@@ design/char_entity_reference_lexer.sv @@
// Top level of the character entity reference lexer.
// Instantiates cerl_front, cerl_queue and cerl_back; uses cerl_pkg and cerl_if.
//
// Usage: each request on in_ch carries an action (feed a character or restart
// the automaton) and an 8-bit code unit. Every accepted request yields exactly
// one result on out_ch with the automaton state, the completion kind
// (none, named or numeric entity), the accumulated numeric value and the
// sticky overflow flag.
// Both channels use valid/ready; a transfer happens when both are high.
// Throughput is one request per clock while out_ch does not stall. A request
// passes in order through the classify register, the two-entry queue and the
// result register. The automaton step and the multiply-by-ten-or-sixteen add
// sit in the back stage.
// When out_ch stalls, the result register holds, the queue fills and then
// in_ch.ready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and puts the automaton
// in its start state with a zero value and a clear overflow flag.
`default_nettype none

module char_entity_reference_lexer (
  input  wire logic clk,
  input  wire logic rst_n,
  cerl_in_if.sink   in_ch,
  cerl_out_if.source out_ch
);

  cerl_pkg::lex_item_t front_item;
  logic                front_valid;
  logic                front_ready;
  cerl_pkg::lex_item_t back_item;
  logic                back_valid;
  logic                back_ready;

  cerl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  cerl_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_item_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_item_o   (back_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  cerl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_i       (back_item),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .out_ch       (out_ch)
  );

endmodule : char_entity_reference_lexer

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for char_entity_reference_lexer.
// Depends on cerl_pkg, cerl_in_if and cerl_out_if from the design folder; a scoreboard
// class predicts each result and random idling on both channels exercises the handshakes.
`default_nettype none

module testbench;
  import cerl_pkg::*;

  localparam int NUM_REQUESTS = 650;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 90;
  localparam int DRAIN_CYCLES = 20;

  // Predicts the lexer from the requests it accepts and checks each result in order.
  class entity_lexer_scoreboard;
    typedef struct {
      lex_state_t  state_now;
      done_kind_t  done_kind;
      logic [31:0] numeric_value;
      logic        too_big;
    } lex_result_t;

    lex_result_t expected_q[$];
    lex_state_t  lex_state;
    logic [63:0] number_acc;
    logic        number_ovf;
    int          mismatches;

    function new();
      lex_state = ST_START;
      number_acc = '0;
      number_ovf = 1'b0;
      mismatches = 0;
    endfunction

    function char_class_t class_of(logic [7:0] c);
      if (c == "&") return CLS_AMP;
      if (c == ";") return CLS_SEMI;
      if (c == "#") return CLS_HASH;
      if (c == "x" || c == "X") return CLS_XCHAR;
      if (c >= "0" && c <= "9") return CLS_DIGIT;
      if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return CLS_HEXL;
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) return CLS_LETTER;
      return CLS_NONE;
    endfunction

    function lex_state_t next_state(lex_state_t s, char_class_t k);
      case (s)
        ST_START: begin
          if (k == CLS_AMP) return ST_AMP;
        end
        ST_AMP: begin
          if (k inside {CLS_LETTER, CLS_XCHAR, CLS_HEXL}) return ST_NAME;
          if (k == CLS_HASH) return ST_HASH;
        end
        ST_NAME: begin
          if (k inside {CLS_LETTER, CLS_XCHAR, CLS_HEXL, CLS_DIGIT}) return ST_NAME;
          if (k == CLS_SEMI) return ST_NAME_DONE;
        end
        ST_HASH: begin
          if (k == CLS_XCHAR) return ST_HEX_X;
          if (k == CLS_DIGIT) return ST_DEC;
        end
        ST_DEC: begin
          if (k == CLS_SEMI) return ST_NUM_DONE;
          if (k == CLS_DIGIT) return ST_DEC;
        end
        ST_HEX_X: begin
          if (k inside {CLS_HEXL, CLS_DIGIT}) return ST_HEX;
        end
        ST_HEX: begin
          if (k == CLS_SEMI) return ST_NUM_DONE;
          if (k inside {CLS_HEXL, CLS_DIGIT}) return ST_HEX;
        end
        default: ;
      endcase
      return ST_REJECT;
    endfunction

    function logic [3:0] digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - 8'h30);
      if (c >= "a" && c <= "f") return 4'(c - 8'h57);
      if (c >= "A" && c <= "F") return 4'(c - 8'h37);
      return 4'd0;
    endfunction

    // The flag is raised when the exact value would no longer fit in VALUE_BITS.
    function void accumulate(logic [63:0] base, logic [63:0] digit);
      logic [63:0] mask;
      mask = (VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);
      if (number_acc > (mask - digit) / base) number_ovf = 1'b1;
      number_acc = (number_acc * base + digit) & mask;
    endfunction

    function void note_request(logic action, logic [7:0] code_unit);
      lex_result_t r;
      done_kind_t  done;
      done = DONE_NONE;
      if (action == ACT_RESTART) begin
        lex_state = ST_START;
      end else begin
        lex_state = next_state(lex_state, class_of(code_unit));
        case (lex_state)
          ST_NAME_DONE: done = DONE_NAMED;
          ST_HASH: begin
            number_acc = '0;
            number_ovf = 1'b0;
          end
          ST_DEC: accumulate(64'd10, 64'(digit_of(code_unit)));
          ST_HEX: accumulate(64'd16, 64'(digit_of(code_unit)));
          ST_NUM_DONE: done = DONE_NUMERIC;
          default: ;
        endcase
      end
      r.state_now = lex_state;
      r.done_kind = done;
      r.numeric_value = number_acc[31:0];
      r.too_big = number_ovf;
      expected_q.push_back(r);
    endfunction

    function void check_result(lex_state_t st, done_kind_t dk, logic [31:0] val, logic big);
      lex_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: state %0d done %0d value %h too_big %0d",
                   st, dk, val, big);
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.state_now || dk !== e.done_kind || val !== e.numeric_value ||
          big !== e.too_big) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected state %0d done %0d value %h too_big %0d,",
                    " got %0d %0d %h %0d"},
                   e.state_now, e.done_kind, e.numeric_value, e.too_big, st, dk, val, big);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cerl_in_if  in_ch();
  cerl_out_if out_ch();

  char_entity_reference_lexer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  entity_lexer_scoreboard lex_sb;
  int sent_count;
  int results_seen = 0;
  int quiet_cycles = 0;
  bit burst_mode[2];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Side 0 is the sender, side 1 the receiver; each flips now and then into a run with no gaps.
  function automatic int draw_gap(int side);
    if ($urandom_range(0, 29) == 0) burst_mode[side] = !burst_mode[side];
    return burst_mode[side] ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'(8'h61 + r) : 8'(8'h41 + r - 26);
  endfunction

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 16) return 8'(8'h61 + r - 10);
    return 8'(8'h41 + r - 16);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  task automatic send_request(logic action, logic [7:0] code_unit);
    int gap;
    gap = draw_gap(0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= action;
    in_ch.code_unit <= code_unit;
    do @(posedge clk); while (!in_ch.ready);
    lex_sb.note_request(action, code_unit);
    sent_count++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(ACT_FEED, s[i]);
  endtask

  task automatic send_named();
    int n;
    n = $urandom_range(1, 8);
    send_request(ACT_FEED, "&");
    send_request(ACT_FEED, pick_letter());
    for (int i = 1; i < n; i++)
      send_request(ACT_FEED, ($urandom_range(0, 3) == 0) ? pick_digit() : pick_letter());
    send_request(ACT_FEED, ";");
  endtask

  task automatic send_decimal();
    int n;
    n = $urandom_range(1, 12);
    send_text("&#");
    for (int i = 0; i < n; i++) send_request(ACT_FEED, pick_digit());
    send_request(ACT_FEED, ";");
  endtask

  task automatic send_hex();
    int n;
    n = $urandom_range(1, 10);
    send_text("&#");
    send_request(ACT_FEED, $urandom_range(0, 1) ? "x" : "X");
    for (int i = 0; i < n; i++) send_request(ACT_FEED, pick_hex());
    send_request(ACT_FEED, ";");
  endtask

  // A plausible prefix cut off by an arbitrary byte.
  task automatic send_broken();
    int n;
    n = $urandom_range(0, 3);
    send_request(ACT_FEED, "&");
    if ($urandom_range(0, 1)) send_request(ACT_FEED, "#");
    for (int i = 0; i < n; i++) send_request(ACT_FEED, pick_digit());
    send_request(ACT_FEED, 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1)) send_request(ACT_FEED, ";");
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) send_request(ACT_FEED, 8'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("FAIL char_entity_reference_lexer");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus two long hold-offs that back the pipeline up.
  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = draw_gap(1);
      if (results_seen % 250 == 200) gap = LONG_HOLD;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      lex_sb.check_result(out_ch.state_now, out_ch.done_kind, out_ch.numeric_value,
                          out_ch.too_big);
      results_seen++;
    end
  end

  initial begin : request_source
    int kind;
    bit paused;
    lex_sb = new();
    sent_count = 0;
    paused = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_FEED;
    in_ch.code_unit <= 8'h00;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: restart, named entity, a character after acceptance, a byte in the reject
    // state, decimal and hex entities, an unclassified character after an ampersand.
    send_request(ACT_RESTART, 8'hFF);
    send_text("&a;");
    send_request(ACT_FEED, "~");
    send_request(ACT_FEED, 8'h80);
    send_request(ACT_RESTART, 8'h00);
    send_text("&#9;");
    send_request(ACT_RESTART, 8'h7F);
    send_text("&#X1f;");
    send_request(ACT_RESTART, 8'h26);
    send_text("&@");
    send_request(ACT_RESTART, 8'hAA);
    send_text("&Z9;");

    while (sent_count < NUM_REQUESTS) begin
      if (!paused && sent_count >= NUM_REQUESTS / 2) begin
        // Hold the input off until the pipeline has drained completely.
        paused = 1'b1;
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (lex_sb.pending() != 0);
      end
      if ($urandom_range(0, 99) < 85) send_request(ACT_RESTART, 8'($urandom_range(0, 255)));
      kind = $urandom_range(0, 99);
      if (kind < 30) send_named();
      else if (kind < 55) send_decimal();
      else if (kind < 80) send_hex();
      else if (kind < 90) send_broken();
      else send_noise();
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (lex_sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (lex_sb.mismatches == 0 && lex_sb.pending() == 0) begin
      $display("PASS char_entity_reference_lexer");
    end else begin
      $display("FAIL char_entity_reference_lexer");
    end
    $finish;
  end
endmodule : testbench

`default_nettype wire

@@ sim.f @@
design/cerl_pkg.sv
design/cerl_if.sv
design/cerl_front.sv
design/cerl_queue.sv
design/cerl_back.sv
design/char_entity_reference_lexer.sv
sim/testbench.sv
